// ===== rtl/lock_led_breathe_demo_controller_assert.svh =====
// Assertion macros of the lock LED controller checker.
`ifndef LOCK_LED_BREATHE_DEMO_CONTROLLER_ASSERT_SVH
`define LOCK_LED_BREATHE_DEMO_CONTROLLER_ASSERT_SVH

// Checked only outside reset.
`define LLBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define LLBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/llbd_pkg.sv =====
// Types, constants and curve function of the lock LED breathe and demo controller.
`default_nettype none

package llbd_pkg;

  localparam int LED_NUM    = 6;
  localparam int PHASE_STEP = 5;
  localparam int ROM_SIZE   = 64;
  localparam int ROM_AW     = 6;
  localparam int LEVEL_MAX  = 100;
  localparam int KNEE       = 80;

  localparam logic [7:0] OFF_LEVEL = 8'hFF;

  // Reset values of the configuration registers
  localparam logic [15:0] IDLE_HOLD_RST = 16'd3000;
  localparam logic [15:0] BOOT_HOLD_RST = 16'd10000;
  localparam logic [7:0]  DEMO_STEP_RST = 8'd45;

  // Lock bits and the LEDs each one drives
  localparam logic [4:0] LOCK_ALL      = 5'b00111;
  localparam logic [LED_NUM-1:0] NUM_MASK    = 6'h20;
  localparam logic [LED_NUM-1:0] CAPS_MASK   = 6'h17;
  localparam logic [LED_NUM-1:0] SCROLL_MASK = 6'h08;

  typedef enum logic [1:0] {
    CFG_IDLE_HOLD = 2'd0,
    CFG_BOOT_HOLD = 2'd1,
    CFG_DEMO_STEP = 2'd2
  } llbd_cfg_idx_t;

  typedef struct packed {
    logic       restart;
    logic [4:0] lock_leds;
  } llbd_tick_t;

  typedef struct packed {
    logic [7:0] level_bit0;
    logic [7:0] level_bit1;
    logic [7:0] level_bit2;
    logic [7:0] level_bit3;
    logic [7:0] level_bit4;
    logic [7:0] level_bit5;
    logic       boot_request;
  } llbd_result_t;

  typedef struct packed {
    logic [15:0] idle_hold;
    logic [15:0] boot_hold;
    logic [7:0]  demo_step;
  } llbd_cfg_t;

  // Breathe shape of the idle demo, levels 0..100
  localparam logic [6:0] RAMP_ROM [ROM_SIZE] = '{
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd0,  7'd0,  7'd0,  7'd0,  7'd1,  7'd2,  7'd3,  7'd4,
    7'd6,  7'd9,  7'd13, 7'd17, 7'd23, 7'd29, 7'd37, 7'd45,
    7'd53, 7'd62, 7'd70, 7'd78, 7'd86, 7'd92, 7'd96, 7'd99,
    7'd100, 7'd99, 7'd96, 7'd92, 7'd86, 7'd78, 7'd70, 7'd62,
    7'd53, 7'd45, 7'd37, 7'd29, 7'd23, 7'd17, 7'd13, 7'd9,
    7'd6,  7'd4,  7'd3,  7'd2,  7'd1,  7'd0,  7'd0,  7'd0,
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
  };

  // Level to inverted compare: slope 2 up to the knee, slope 5 above, floor 0
  function automatic logic [7:0] curve(input logic [6:0] n);
    logic [8:0] on;
    if (n <= 7'(KNEE)) begin
      on = {1'b0, n, 1'b0};
    end else begin
      on = 9'd155 + 9'(n - 7'(KNEE)) * 9'd5;
    end
    return (on >= 9'd255) ? 8'd0 : 8'(9'd255 - on);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/llbd_core.sv =====
// Tick state of the controller: breathe ramp, boot countdown, idle demo, LED levels.
`default_nettype none

module llbd_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire llbd_pkg::llbd_cfg_t   cfg,
  input  wire logic                  advance,
  input  wire llbd_pkg::llbd_tick_t  tick,
  output llbd_pkg::llbd_result_t     result_next
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int LN    = llbd_pkg::LED_NUM;

  logic              skip_phase;
  logic [15:0]       boot_count;
  logic [15:0]       demo_wait;
  logic [6:0]        dim_level;
  logic              dim_falling;
  logic [7:0]        step_timer;
  logic [IDX_W-1:0]  demo_index;
  logic [7:0]        levels [LN];

  logic              skip_phase_next;
  logic [15:0]       boot_count_next;
  logic [15:0]       demo_wait_next;
  logic [6:0]        dim_level_next;
  logic              dim_falling_next;
  logic [7:0]        step_timer_next;
  logic [IDX_W-1:0]  demo_index_next;
  logic [7:0]        levels_next [LN];
  logic              boot_next;

  logic [7:0]        demo_entry [LN];

  // Demo table entry per LED, phase shifted by an offset of PHASE_STEP per LED
  for (genvar i = 0; i < LN; i++) begin : g_demo
    localparam int OFFSET = (i * llbd_pkg::PHASE_STEP) % TABLE_DEPTH;
    logic [IDX_W:0]              sum;
    logic [IDX_W:0]              wrapped;
    logic [llbd_pkg::ROM_AW-1:0] rom_idx;
    always_comb begin
      sum     = {1'b0, demo_index} + (IDX_W + 1)'(OFFSET);
      wrapped = (sum >= (IDX_W + 1)'(TABLE_DEPTH)) ? sum - (IDX_W + 1)'(TABLE_DEPTH) : sum;
      rom_idx = llbd_pkg::ROM_AW'(wrapped);
      if (9'(wrapped) < 9'(llbd_pkg::ROM_SIZE)) begin
        demo_entry[i] = llbd_pkg::curve(llbd_pkg::RAMP_ROM[rom_idx]);
      end else begin
        demo_entry[i] = llbd_pkg::OFF_LEVEL;
      end
    end
  end

  // Maintenance step for one tick
  logic [2:0]    lock3;
  logic          ramp_clear;
  logic [6:0]    lvl0;
  logic          fall0;
  logic [6:0]    lvl1;
  logic [6:0]    lvl_up;
  logic [15:0]   boot_dec;
  logic [LN-1:0] mask;
  logic [7:0]    breathe;

  always_comb begin
    lock3      = tick.lock_leds[2:0];
    ramp_clear = (demo_wait != cfg.idle_hold);
    lvl0       = ramp_clear ? 7'd0 : dim_level;
    fall0      = ramp_clear ? 1'b0 : dim_falling;
    lvl1       = fall0 ? lvl0 - 7'd1 : lvl0;
    lvl_up     = lvl1 + 7'd1;
    boot_dec   = boot_count - 16'd1;
    breathe    = llbd_pkg::curve(lvl1);
    mask       = '0;
    if (lock3[0]) mask = mask | llbd_pkg::NUM_MASK;
    if (lock3[1]) mask = mask | llbd_pkg::CAPS_MASK;
    if (lock3[2]) mask = mask | llbd_pkg::SCROLL_MASK;
  end

  always_comb begin
    skip_phase_next  = skip_phase;
    boot_count_next  = boot_count;
    demo_wait_next   = demo_wait;
    dim_level_next   = dim_level;
    dim_falling_next = dim_falling;
    step_timer_next  = step_timer;
    demo_index_next  = demo_index;
    boot_next        = 1'b0;
    for (int i = 0; i < LN; i++) begin
      levels_next[i] = levels[i];
    end

    if (tick.restart) begin
      boot_count_next  = cfg.boot_hold;
      demo_wait_next   = cfg.idle_hold;
      skip_phase_next  = 1'b0;
      dim_falling_next = 1'b0;
      dim_level_next   = 7'd0;
      for (int i = 0; i < LN; i++) begin
        levels_next[i] = llbd_pkg::OFF_LEVEL;
      end
    end else if (skip_phase) begin
      skip_phase_next = 1'b0;
    end else begin
      skip_phase_next = 1'b1;
      if (lock3 != 3'd0) begin
        // Breathe the LEDs of the active locks; with all locks on, count down to the boot request
        demo_wait_next = cfg.idle_hold;
        if (tick.lock_leds == llbd_pkg::LOCK_ALL) begin
          if (boot_dec == 16'd0) begin
            boot_next       = 1'b1;
            boot_count_next = cfg.boot_hold;
          end else begin
            boot_count_next = boot_dec;
          end
        end else begin
          boot_count_next = cfg.boot_hold;
        end
        for (int i = 0; i < LN; i++) begin
          levels_next[i] = mask[i] ? breathe : llbd_pkg::OFF_LEVEL;
        end
        if (fall0) begin
          dim_level_next   = lvl1;
          dim_falling_next = (lvl1 != 7'd0);
        end else if (lvl_up > 7'(llbd_pkg::LEVEL_MAX)) begin
          dim_level_next   = lvl_up - 7'd2;
          dim_falling_next = 1'b1;
        end else begin
          dim_level_next   = lvl_up;
          dim_falling_next = 1'b0;
        end
      end else if (demo_wait != 16'd0) begin
        // Idle countdown before the demo
        if (demo_wait == cfg.idle_hold) begin
          for (int i = 0; i < LN; i++) begin
            levels_next[i] = llbd_pkg::OFF_LEVEL;
          end
        end
        demo_wait_next = demo_wait - 16'd1;
        if (demo_wait == 16'd1) begin
          step_timer_next = 8'd0;
          demo_index_next = '0;
        end
      end else if (step_timer != 8'd0) begin
        step_timer_next = step_timer - 8'd1;
      end else begin
        // Demo table advance
        step_timer_next = cfg.demo_step;
        for (int i = 0; i < LN; i++) begin
          levels_next[i] = demo_entry[i];
        end
        demo_index_next = (demo_index == IDX_W'(TABLE_DEPTH - 1)) ? '0 : demo_index + 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_phase  <= 1'b0;
      boot_count  <= llbd_pkg::BOOT_HOLD_RST;
      demo_wait   <= llbd_pkg::IDLE_HOLD_RST;
      dim_level   <= 7'd0;
      dim_falling <= 1'b0;
      step_timer  <= 8'd0;
      demo_index  <= '0;
      for (int i = 0; i < LN; i++) begin
        levels[i] <= llbd_pkg::OFF_LEVEL;
      end
    end else if (advance) begin
      skip_phase  <= skip_phase_next;
      boot_count  <= boot_count_next;
      demo_wait   <= demo_wait_next;
      dim_level   <= dim_level_next;
      dim_falling <= dim_falling_next;
      step_timer  <= step_timer_next;
      demo_index  <= demo_index_next;
      for (int i = 0; i < LN; i++) begin
        levels[i] <= levels_next[i];
      end
    end
  end

  assign result_next.level_bit0   = levels_next[0];
  assign result_next.level_bit1   = levels_next[1];
  assign result_next.level_bit2   = levels_next[2];
  assign result_next.level_bit3   = levels_next[3];
  assign result_next.level_bit4   = levels_next[4];
  assign result_next.level_bit5   = levels_next[5];
  assign result_next.boot_request = boot_next;

endmodule

`default_nettype wire

// ===== rtl/lock_led_breathe_demo_controller.sv =====
// Top level of the lock LED breathe and idle demo controller.
//
//   channel  | valid/ready               | payload
//   ---------+---------------------------+--------------------------
//   tick     | tick_valid/tick_ready     | tick (restart, lock_leds)
//   result   | result_valid/result_ready | result (six levels, boot)
//   config   | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// One tick request is taken every cycle while tick_ready is high.
// The tick sits in an input register; one pass of logic updates state into
// the result register. reset clears config to defaults and the pipeline.
// When result_ready is low the result holds and the input register fills,
// then tick_ready drops. cfg_ready is always high.
`default_nettype none

module lock_led_breathe_demo_controller #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    tick_valid,
  output logic                         tick_ready,
  input  wire llbd_pkg::llbd_tick_t    tick,
  output logic                         result_valid,
  input  wire logic                    result_ready,
  output llbd_pkg::llbd_result_t       result,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [15:0]             cfg_data
);

  llbd_pkg::llbd_cfg_t    cfg;
  logic                   s0_valid;
  llbd_pkg::llbd_tick_t   s0_tick;
  logic                   advance;
  llbd_pkg::llbd_result_t result_next;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_hold <= llbd_pkg::IDLE_HOLD_RST;
      cfg.boot_hold <= llbd_pkg::BOOT_HOLD_RST;
      cfg.demo_step <= llbd_pkg::DEMO_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        llbd_pkg::CFG_IDLE_HOLD: cfg.idle_hold <= cfg_data;
        llbd_pkg::CFG_BOOT_HOLD: cfg.boot_hold <= cfg_data;
        llbd_pkg::CFG_DEMO_STEP: cfg.demo_step <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: input register feeds the result register
  assign advance    = s0_valid && (!result_valid || result_ready);
  assign tick_ready = !s0_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (tick_ready) begin
      s0_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_ready && tick_valid) begin
      s0_tick <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // Tick state and LED level logic
  llbd_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .advance    (advance),
    .tick       (s0_tick),
    .result_next(result_next)
  );

endmodule

`default_nettype wire

// ===== rtl/llbd_checker.sv =====
// Port-level checks of the lock LED controller, bound to the top level.
`default_nettype none

`include "lock_led_breathe_demo_controller_assert.svh"

module llbd_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   tick_ready,
  input wire logic                   result_valid,
  input wire logic                   result_ready,
  input wire llbd_pkg::llbd_result_t result
);

  // Nothing is shown right after reset
  `LLBD_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")

  // An empty result register never blocks a new tick
  `LLBD_ASSERT(a_ready_when_empty, !result_valid |-> tick_ready, "tick stalled with empty output")

  // A stalled result holds
  `LLBD_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result),
    "stalled result changed")

  // Boot request only with all three locks: LEDs 0, 1, 3 and 5 show the same level
  `LLBD_ASSERT(a_boot_all_leds, result_valid && result.boot_request |->
    result.level_bit0 == result.level_bit5 && result.level_bit3 == result.level_bit5 &&
    result.level_bit1 == result.level_bit5, "boot request without all locks lit")

endmodule

bind lock_led_breathe_demo_controller llbd_checker u_llbd_checker (.*);

`default_nettype wire
